// ===== sv/aagc_pkg.sv =====
package aagc_pkg;

    // fixed width of the lifetime threshold registers
    localparam int LIFE_W = 32;
    localparam int NUM_LIFE = 3;
    localparam int CFG_IDX_W = 2;

    // digit processed per cycle by the serial accumulators
    localparam int DIGIT_W = 8;

    localparam int HISTORY_DEPTH_DEF = 5;
    localparam int TIME_WIDTH_DEF = 32;
    // padded accumulator width for the default configuration
    localparam int ACC_W_DEF = 40;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } acc_ctrl_t;

endpackage

// ===== sv/access_age_generation_classifier.sv =====
// Access-age generation classifier. A use beat (action 0) stores now_ticks in
// a ring of the last HISTORY_DEPTH stamps and goes straight to the output stage. An
// update beat (action 1) sets the generation from the exact age of now_ticks
// against the mean of the stored stamps, and a query beat (action 2) flags an
// idle interval since the newest stamp that no longer fits the generation.
// Update and query run three digit-serial accumulators, one per lifetime
// threshold, that walk the stored stamps one DIGIT_W-bit digit per cycle:
// each stamp is loaded and then shifted through its NDIG digits, over every
// stored stamp for an update (one zero term when the ring is empty) and over
// the newest stamp for a query; with the defaults NDIG is 5.
// One beat is in work at a time; a finished result sits in the output
// register until taken. Lifetime registers are to be written through cfg_we
// only while idle; the block does not enforce it. Thresholds are used as given.
module access_age_generation_classifier #(
    parameter int TIME_WIDTH    = aagc_pkg::TIME_WIDTH_DEF,
    parameter int HISTORY_DEPTH = aagc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [TIME_WIDTH-1:0]           now_ticks,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      generation,
    output logic                            out_of_time,

    input  logic                            cfg_we,
    input  logic [aagc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aagc_pkg::LIFE_W-1:0]     cfg_data
);

    localparam int LIFE_W = aagc_pkg::LIFE_W;
    localparam int DW     = aagc_pkg::DIGIT_W;
    // magnitude of one term (stamp + lifetime - now), then room for the sum
    localparam int MAG_W  = ((TIME_WIDTH > LIFE_W) ? TIME_WIDTH : LIFE_W) + 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int ACC_W  = MAG_W + CNT_W + 1;
    localparam int NDIG   = (ACC_W + DW - 1) / DW;
    localparam int ACC_PAD = NDIG * DW;
    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DCNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic [1:0] ACT_USE    = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] GEN_0   = 2'd0;
    localparam logic [1:0] GEN_1   = 2'd1;
    localparam logic [1:0] GEN_2   = 2'd2;
    localparam logic [1:0] GEN_TOP = 2'd3;

    localparam logic [aagc_pkg::CFG_IDX_W-1:0] CFG_LIFE0 = 2'd0;
    localparam logic [aagc_pkg::CFG_IDX_W-1:0] CFG_LIFE1 = 2'd1;
    localparam logic [aagc_pkg::CFG_IDX_W-1:0] CFG_LIFE2 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_EVAL,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [1:0]          action_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [IDX_W-1:0]    entry_reg;
    logic [DCNT_W-1:0]   digit_reg;
    logic                flag_reg;
    logic [1:0]          gen_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                out_valid_reg;
    logic [1:0]          generation_reg;
    logic                out_of_time_reg;

    // stamp ring, contents undefined until written
    logic [TIME_WIDTH-1:0] ring_reg [HISTORY_DEPTH];

    logic [LIFE_W-1:0]   life_reg [aagc_pkg::NUM_LIFE];

    logic [ACC_PAD-1:0]  ring_sr_reg;
    logic [ACC_PAD-1:0]  now_sr_reg;

    logic                    accept;
    logic                    last_digit;
    logic                    last_entry;
    logic [CNT_W-1:0]        pass_total;
    logic [IDX_W-1:0]        newest;
    logic [IDX_W-1:0]        slot_inc;
    logic [IDX_W-1:0]        rd_idx;
    logic [aagc_pkg::NUM_LIFE-1:0] exceeds;
    logic                    e_hi;
    logic                    e_lo;
    logic [1:0]              gen_class;
    logic                    query_flag;
    aagc_pkg::acc_ctrl_t     acc_ctrl;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign generation  = generation_reg;
    assign out_of_time = out_of_time_reg;

    // ring slot bookkeeping
    assign slot_inc = (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
    assign newest   = (slot_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : slot_reg - IDX_W'(1);

    // update walks slots 0 .. count-1 (one zero term on an empty ring); query reads the newest
    assign rd_idx     = (action_reg == ACT_QUERY) ? newest : entry_reg;
    assign pass_total = (action_reg == ACT_UPDATE && count_reg != '0) ? count_reg : CNT_W'(1);
    assign last_entry = ((CNT_W'(entry_reg) + CNT_W'(1)) == pass_total);
    assign last_digit = (digit_reg == DCNT_W'(NDIG - 1));

    assign acc_ctrl.clear = accept;
    assign acc_ctrl.load  = (state_reg == ST_LOAD);
    assign acc_ctrl.shift = (state_reg == ST_RUN);

    // three threshold lanes, each ends with the sign of sum(stamp + L - now)
    for (genvar k = 0; k < aagc_pkg::NUM_LIFE; k++)
    begin : g_lane
        aagc_digit_acc #(
            .ACC_W (ACC_PAD)
        ) u_acc (
            .clk        (clk),
            .ctrl       (acc_ctrl),
            .lifetime   (life_reg[k]),
            .ring_digit (ring_sr_reg[DW-1:0]),
            .now_digit  (now_sr_reg[DW-1:0]),
            .sign       (exceeds[k])
        );
    end

    // generation from the first threshold that the age does not exceed
    always_comb
    begin
        if (!exceeds[0])
        begin
            gen_class = GEN_0;
        end
        else if (!exceeds[1])
        begin
            gen_class = GEN_1;
        end
        else if (!exceeds[2])
        begin
            gen_class = GEN_2;
        end
        else
        begin
            gen_class = GEN_TOP;
        end
    end

    // idle interval against own limit (hi) and the one below (lo)
    always_comb
    begin
        case (gen_reg)
            GEN_0:
            begin
                e_hi = exceeds[0];
                e_lo = 1'b1;
            end
            GEN_1:
            begin
                e_hi = exceeds[1];
                e_lo = exceeds[0];
            end
            GEN_2:
            begin
                e_hi = exceeds[2];
                e_lo = exceeds[1];
            end
            default:
            begin
                e_hi = 1'b0;
                e_lo = exceeds[2];
            end
        endcase
    end

    assign query_flag = (gen_reg != GEN_TOP && e_hi) || (gen_reg != GEN_0 && !e_lo);

    // lifetime registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aagc_pkg::NUM_LIFE; i++)
            begin
                life_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIFE0: life_reg[0] <= cfg_data;
                CFG_LIFE1: life_reg[1] <= cfg_data;
                CFG_LIFE2: life_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stamp ring write
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_USE)
        begin
            ring_reg[slot_reg] <= now_ticks;
        end
    end

    // operand shift registers; now goes in inverted so each term subtracts it
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            if (action_reg == ACT_UPDATE && count_reg == '0)
            begin
                ring_sr_reg <= '0;
            end
            else
            begin
                ring_sr_reg <= ACC_PAD'(ring_reg[rd_idx]);
            end
            now_sr_reg <= ~ACC_PAD'(now_reg);
        end
        else if (state_reg == ST_RUN)
        begin
            ring_sr_reg <= ring_sr_reg >> DW;
            now_sr_reg  <= now_sr_reg >> DW;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            action_reg      <= ACT_USE;
            now_reg         <= '0;
            entry_reg       <= '0;
            digit_reg       <= '0;
            flag_reg        <= 1'b0;
            gen_reg         <= GEN_TOP;
            count_reg       <= '0;
            slot_reg        <= '0;
            out_valid_reg   <= 1'b0;
            generation_reg  <= GEN_TOP;
            out_of_time_reg <= 1'b0;
        end
        else
        begin
            // the output stage reloads the register itself
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg <= action;
                        now_reg    <= now_ticks;
                        entry_reg  <= '0;
                        flag_reg   <= 1'b0;
                        case (action)
                            ACT_USE:
                            begin
                                slot_reg <= slot_inc;
                                if (count_reg != CNT_W'(HISTORY_DEPTH))
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                state_reg <= ST_OUT;
                            end
                            ACT_UPDATE:
                            begin
                                state_reg <= ST_LOAD;
                            end
                            ACT_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    // nothing recorded: only the top generation fits
                                    flag_reg  <= (gen_reg != GEN_TOP);
                                    state_reg <= ST_OUT;
                                end
                                else
                                begin
                                    state_reg <= ST_LOAD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    digit_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    digit_reg <= digit_reg + DCNT_W'(1);
                    if (last_digit)
                    begin
                        if (last_entry)
                        begin
                            state_reg <= ST_EVAL;
                        end
                        else
                        begin
                            entry_reg <= entry_reg + IDX_W'(1);
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_EVAL:
                begin
                    if (action_reg == ACT_UPDATE)
                    begin
                        gen_reg <= gen_class;
                    end
                    else
                    begin
                        flag_reg <= query_flag;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        generation_reg  <= gen_reg;
                        out_of_time_reg <= flag_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // until the ring wraps, stamps fill slots 0 .. count-1 in order
    a_slot_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(HISTORY_DEPTH)) |-> (CNT_W'(slot_reg) == count_reg))
        else $error("write slot out of step with stamp count");

    // generation moves only at the end of an update
    a_gen_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(gen_reg) |-> $past(state_reg == ST_EVAL && action_reg == ACT_UPDATE))
        else $error("generation changed outside an update");

    // a result beat appears only from the output stage
    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result beat without a finished item");

    // the digit walk never runs past the padded accumulator
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (digit_reg <= DCNT_W'(NDIG - 1)))
        else $error("digit counter overran");
`endif

endmodule

// ===== sv/aagc_digit_acc.sv =====
// digit-serial accumulator of (stamp + lifetime - now) terms, lsb digit first
module aagc_digit_acc #(
    parameter int ACC_W = aagc_pkg::ACC_W_DEF
) (
    input  logic                         clk,
    input  aagc_pkg::acc_ctrl_t          ctrl,
    input  logic [aagc_pkg::LIFE_W-1:0]  lifetime,
    input  logic [aagc_pkg::DIGIT_W-1:0] ring_digit,
    input  logic [aagc_pkg::DIGIT_W-1:0] now_digit,
    output logic                         sign
);

    localparam int DW = aagc_pkg::DIGIT_W;
    localparam int SUM_W = DW + 2;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] life_sr_reg;
    logic [1:0]       carry_reg;
    logic [SUM_W-1:0] digit_sum;

    assign digit_sum = SUM_W'(acc_reg[DW-1:0]) + SUM_W'(life_sr_reg[DW-1:0])
                     + SUM_W'(ring_digit) + SUM_W'(now_digit) + SUM_W'(carry_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            acc_reg <= {digit_sum[DW-1:0], acc_reg[ACC_W-1:DW]};
        end

        // carry starts at one: the +1 of the two's complement of now
        if (ctrl.load)
        begin
            life_sr_reg <= ACC_W'(lifetime);
            carry_reg   <= 2'd1;
        end
        else if (ctrl.shift)
        begin
            life_sr_reg <= life_sr_reg >> DW;
            carry_reg   <= digit_sum[SUM_W-1:DW];
        end
    end

    assign sign = acc_reg[ACC_W-1];

endmodule
